### rtl/core/ppsc_pkg.sv
package ppsc_pkg;

	localparam int CW    = 16;
	localparam int NFB   = 14;
	localparam int PW    = 3 * CW;
	localparam int RW    = 16;
	localparam int DW    = 18;
	localparam int EW    = CW + 1;
	localparam int CRW   = 2 * EW + 1;
	localparam int SW    = 2 * CRW;
	localparam int REMW  = CRW + 4;
	localparam int NUMW  = CRW + NFB;
	localparam int DREMW = CRW + 1;
	localparam int NW    = NFB + 2;
	localparam int ACCW  = CRW + 1;
	localparam int OFFW  = ACCW - NFB;
	localparam int DFW   = OFFW + 1;
	localparam int CNTW  = $clog2(NUMW + 2);
	localparam int ITW   = ((4 * CW + 7) / 8) * 8;
	localparam int OBW   = DW + 4;
	localparam int OTW   = ((OBW + 7) / 8) * 8;

	localparam logic [1:0] REG_A = 2'd0;
	localparam logic [1:0] REG_B = 2'd1;
	localparam logic [1:0] REG_C = 2'd2;

	localparam logic [1:0] SIDE_NEG = 2'd0;
	localparam logic [1:0] SIDE_ON  = 2'd1;
	localparam logic [1:0] SIDE_POS = 2'd2;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CROSS = 8'b0000_0010,
		ST_SQ    = 8'b0000_0100,
		ST_SQRT  = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_OFF   = 8'b0010_0000,
		ST_DOT   = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	function automatic logic signed [CW-1:0] coord_of(input logic [PW-1:0] p,
			input logic [1:0] i);
		return p[i*CW +: CW];
	endfunction

endpackage

### rtl/core/plane_point_side_classifier.sv
// Query path: an accepted query runs through ST_DOT, where one multiplier takes one coordinate
// product per cycle, the last held while a previous result waits; the result is registered there
// and m_tvalid rises from ST_FIN. After reset or any configuration write the first query first
// derives the plane: cross product, bit-serial squaring, square root and division, then the offset;
// division and offset are skipped when the plane is degenerate. New queries are taken only in ST_IDLE.
// Reset clears the plane points, the normal, the offset and the output valid flag, not the output data.
module plane_point_side_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ppsc_pkg::PW-1:0]       cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// point_x, point_y, point_z, sphere_radius
	input  logic [ppsc_pkg::ITW-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// signed_distance, side, colliding, plane_degenerate, zero padding
	output logic [ppsc_pkg::OTW-1:0]      m_tdata
);
	import ppsc_pkg::*;

	state_t state_q;
	logic [PW-1:0] pa_q, pb_q, pc_q;
	logic signed [NW-1:0] nrm_q [3];
	logic signed [OFFW-1:0] off_q;
	logic rdy_q, degen_q;
	logic signed [CW-1:0] pt_q [3];
	logic [RW-1:0] rad_q;
	logic [CNTW-1:0] k_q;
	logic [1:0] ci_q;
	logic signed [ACCW-1:0] acc_q;
	logic [CRW-1:0] mg_q [3];
	logic [2:0] cs_q;
	logic [SW-1:0] sum_q, md_q, srad_q;
	logic [CRW-1:0] mr_q, root_q;
	logic [REMW-1:0] rem_q;
	logic [NUMW-1:0] num_q;
	logic [DREMW-1:0] drem_q;
	logic [NW-1:0] quo_q;
	logic mv_q;
	logic signed [DW-1:0] dist_q;
	logic [1:0] side_q;
	logic coll_q, odeg_q;

	logic signed [EW-1:0] e1 [3];
	logic signed [EW-1:0] e2 [3];
	logic signed [EW-1:0] ma, mb;
	logic signed [2*EW-1:0] prod;
	logic signed [ACCW-1:0] dot;
	logic signed [CRW-1:0] crv;
	logic [REMW-1:0] remn, trial;
	logic [DREMW-1:0] dn;
	logic signed [DFW-1:0] dfull;
	logic [DFW-1:0] dmag;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = EW'(coord_of(pa_q, 2'(i))) - EW'(coord_of(pb_q, 2'(i)));
			e2[i] = EW'(coord_of(pc_q, 2'(i))) - EW'(coord_of(pb_q, 2'(i)));
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_CROSS: begin
				unique case (k_q[2:0])
					3'd0: begin ma = e1[1]; mb = e2[2]; end
					3'd1: begin ma = e1[2]; mb = e2[1]; end
					3'd2: begin ma = e1[2]; mb = e2[0]; end
					3'd3: begin ma = e1[0]; mb = e2[2]; end
					3'd4: begin ma = e1[0]; mb = e2[1]; end
					default: begin ma = e1[1]; mb = e2[0]; end
				endcase
			end
			ST_OFF: begin
				ma = EW'(nrm_q[k_q[1:0]]);
				mb = EW'(coord_of(pa_q, k_q[1:0]));
			end
			ST_DOT: begin
				ma = EW'(nrm_q[k_q[1:0]]);
				mb = EW'(pt_q[k_q[1:0]]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod  = ma * mb;
	assign dot   = acc_q + ACCW'(prod);
	assign crv   = CRW'(acc_q - ACCW'(prod));
	assign remn  = {rem_q[REMW-3:0], srad_q[SW-1:SW-2]};
	assign trial = REMW'({root_q, 2'b01});
	assign dn    = {drem_q[DREMW-2:0], num_q[NUMW-1]};
	assign dfull = DFW'(dot >>> NFB) - DFW'(off_q);
	assign dmag  = dfull[DFW-1] ? DFW'(-dfull) : DFW'(dfull);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mv_q;
	assign m_tdata  = OTW'({odeg_q, coll_q, side_q, dist_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pa_q <= '0;
			pb_q <= '0;
			pc_q <= '0;
			for (int i = 0; i < 3; i++) begin
				nrm_q[i] <= '0;
			end
			off_q <= '0;
			rdy_q <= 1'b0;
			degen_q <= 1'b0;
			mv_q <= 1'b0;
		end else begin
			if (mv_q && m_tready) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						pt_q[0] <= s_tdata[0 +: CW];
						pt_q[1] <= s_tdata[CW +: CW];
						pt_q[2] <= s_tdata[2*CW +: CW];
						rad_q <= s_tdata[3*CW +: RW];
						k_q <= '0;
						state_q <= rdy_q ? ST_DOT : ST_CROSS;
					end
				end
				ST_CROSS: begin
					if (!k_q[0]) begin
						acc_q <= ACCW'(prod);
					end else begin
						mg_q[k_q[2:1]] <= crv[CRW-1] ? CRW'(-crv) : CRW'(crv);
						cs_q[k_q[2:1]] <= crv[CRW-1];
					end
					if (k_q == CNTW'(5)) begin
						k_q <= '0;
						ci_q <= '0;
						sum_q <= '0;
						state_q <= ST_SQ;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SQ: begin
					if (k_q == '0) begin
						md_q <= SW'(mg_q[ci_q]);
						mr_q <= mg_q[ci_q];
					end else begin
						if (mr_q[0]) begin
							sum_q <= sum_q + md_q;
						end
						md_q <= md_q << 1;
						mr_q <= mr_q >> 1;
					end
					if (k_q == CNTW'(CRW)) begin
						k_q <= '0;
						if (ci_q == 2'd2) begin
							state_q <= ST_SQRT;
						end else begin
							ci_q <= ci_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (k_q == '0) begin
						srad_q <= sum_q;
						rem_q <= '0;
						root_q <= '0;
						k_q <= k_q + 1'b1;
					end else if (k_q <= CNTW'(CRW)) begin
						if (remn >= trial) begin
							rem_q <= remn - trial;
							root_q <= {root_q[CRW-2:0], 1'b1};
						end else begin
							rem_q <= remn;
							root_q <= {root_q[CRW-2:0], 1'b0};
						end
						srad_q <= srad_q << 2;
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						ci_q <= '0;
						if (root_q == '0) begin
							for (int i = 0; i < 3; i++) begin
								nrm_q[i] <= '0;
							end
							off_q <= '0;
							degen_q <= 1'b1;
							rdy_q <= 1'b1;
							state_q <= ST_DOT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (k_q == '0) begin
						num_q <= {mg_q[ci_q], NFB'(0)};
						drem_q <= '0;
						quo_q <= '0;
						k_q <= k_q + 1'b1;
					end else if (k_q <= CNTW'(NUMW)) begin
						if (dn >= {1'b0, root_q}) begin
							drem_q <= dn - {1'b0, root_q};
							quo_q <= {quo_q[NW-2:0], 1'b1};
						end else begin
							drem_q <= dn;
							quo_q <= {quo_q[NW-2:0], 1'b0};
						end
						num_q <= num_q << 1;
						k_q <= k_q + 1'b1;
					end else begin
						nrm_q[ci_q] <= cs_q[ci_q] ? -$signed(quo_q) : $signed(quo_q);
						k_q <= '0;
						if (ci_q == 2'd2) begin
							state_q <= ST_OFF;
						end else begin
							ci_q <= ci_q + 1'b1;
						end
					end
				end
				ST_OFF: begin
					acc_q <= (k_q == '0) ? ACCW'(prod) : dot;
					if (k_q == CNTW'(2)) begin
						off_q <= OFFW'(dot >>> NFB);
						degen_q <= 1'b0;
						rdy_q <= 1'b1;
						k_q <= '0;
						state_q <= ST_DOT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DOT: begin
					if (k_q != CNTW'(2)) begin
						acc_q <= (k_q == '0) ? ACCW'(prod) : dot;
						k_q <= k_q + 1'b1;
					end else if (!mv_q || m_tready) begin
						if (dfull > DFW'((1 <<< (DW - 1)) - 1)) begin
							dist_q <= DW'((1 <<< (DW - 1)) - 1);
						end else if (dfull < -DFW'(1 <<< (DW - 1))) begin
							dist_q <= DW'(-(1 <<< (DW - 1)));
						end else begin
							dist_q <= DW'(dfull);
						end
						if (dfull[DFW-1]) begin
							side_q <= SIDE_NEG;
						end else if (dfull == '0) begin
							side_q <= SIDE_ON;
						end else begin
							side_q <= SIDE_POS;
						end
						coll_q <= (dmag <= DFW'(rad_q));
						odeg_q <= degen_q;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					mv_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					REG_A: begin pa_q <= cfg_data; rdy_q <= 1'b0; end
					REG_B: begin pb_q <= cfg_data; rdy_q <= 1'b0; end
					REG_C: begin pc_q <= cfg_data; rdy_q <= 1'b0; end
					default: begin end
				endcase
			end
		end
	end

endmodule

### dv/tb_plane_point_side_classifier.sv
module tb_plane_point_side_classifier;
	timeunit 1ns;
	timeprecision 1ps;
	import ppsc_pkg::*;

	typedef struct packed {
		logic [RW-1:0]        radius;
		logic signed [CW-1:0] pz;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] px;
	} query_t;

	typedef struct packed {
		logic                 degen;
		logic                 coll;
		logic [1:0]           side;
		logic signed [DW-1:0] distance;
	} answer_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  idx;
		logic [PW-1:0] val;
		query_t      q;
		bit          typed;
		answer_t     ans;
	} row_t;

	localparam longint LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_A;
	logic [PW-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ITW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OTW-1:0] m_tdata;

	logic [PW-1:0] pt_a, pt_b, pt_c;
	longint nrm [3];
	longint offs;
	bit plane_valid, degen_flag;
	answer_t answers_due[$];
	int errors = 0;
	longint cycles = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_recv = 1'b0;

	always #2 clk = ~clk;

	plane_point_side_classifier u_top (.*);

	function automatic longint coord(logic [PW-1:0] p, int i);
		logic signed [CW-1:0] c;
		c = p[i*CW +: CW];
		return longint'(c);
	endfunction

	function automatic longint floor_frac(longint v);
		return v >>> NFB;
	endfunction

	function automatic void derive_normal();
		longint e1 [3], e2 [3], cr [3], len, m;
		logic [127:0] sq, r, t;
		e1 = '{0, 0, 0};
		e2 = '{0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			e1[i] = coord(pt_a, i) - coord(pt_b, i);
			e2[i] = coord(pt_c, i) - coord(pt_b, i);
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			m = cr[i] < 0 ? -cr[i] : cr[i];
			sq += 128'(m) * 128'(m);
		end
		r = '0;
		for (int b = 2 * CW + 3; b >= 0; b--) begin
			t = r | (128'd1 << b);
			if (t * t <= sq)
				r = t;
		end
		len = longint'(r);
		if (len == 0) begin
			nrm = '{0, 0, 0};
			offs = 0;
			degen_flag = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				m = cr[i] < 0 ? -cr[i] : cr[i];
				m = (m << NFB) / len;
				nrm[i] = cr[i] < 0 ? -m : m;
			end
			offs = floor_frac(nrm[0] * coord(pt_a, 0) + nrm[1] * coord(pt_a, 1)
				+ nrm[2] * coord(pt_a, 2));
			degen_flag = 1'b0;
		end
		plane_valid = 1'b1;
	endfunction

	function automatic answer_t classify(query_t q);
		answer_t a;
		longint d, s;
		if (!plane_valid)
			derive_normal();
		d = floor_frac(nrm[0] * q.px + nrm[1] * q.py + nrm[2] * q.pz) - offs;
		s = d > 131071 ? 131071 : (d < -131072 ? -131072 : d);
		a.distance = s[DW-1:0];
		a.side = d < 0 ? SIDE_NEG : (d > 0 ? SIDE_POS : SIDE_ON);
		a.coll = (d < 0 ? -d : d) <= longint'(q.radius);
		a.degen = degen_flag;
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [PW-1:0] val);
		wait_drained();
		repeat (400) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_A: pt_a = val;
			REG_B: pt_b = val;
			default: pt_c = val;
		endcase
		plane_valid = 1'b0;
	endtask

	task automatic send_query(query_t q, bit typed, answer_t want);
		answer_t a;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		a = classify(q);
		if (typed && a != want)
			report_mismatch("typed row", a, want);
		s_tvalid <= 1'b1;
		s_tdata <= ITW'(q);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		answers_due.push_back(a);
	endtask

	function automatic logic [PW-1:0] pack_pt(longint x, longint y, longint z);
		return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
	endfunction

	function automatic query_t mk_q(longint x, longint y, longint z, longint r);
		query_t q;
		q.px = x[CW-1:0];
		q.py = y[CW-1:0];
		q.pz = z[CW-1:0];
		q.radius = r[RW-1:0];
		return q;
	endfunction

	function automatic query_t rand_q(bit narrow);
		query_t q;
		q = query_t'({$urandom, $urandom});
		if (narrow) begin
			q.px = $signed(16'($urandom_range(2048))) - 16'sd1024;
			q.py = $signed(16'($urandom_range(2048))) - 16'sd1024;
			q.pz = $signed(16'($urandom_range(2048))) - 16'sd1024;
			q.radius = 16'($urandom_range(1024));
		end
		return q;
	endfunction

	function automatic logic [PW-1:0] rand_pt(bit narrow);
		if (narrow)
			return pack_pt($urandom_range(4096) - 2048, $urandom_range(4096) - 2048,
				$urandom_range(4096) - 2048);
		return PW'({$urandom, $urandom});
	endfunction

	always @(posedge clk) begin
		if (hold_recv)
			m_tready <= 1'b0;
		else
			m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		answer_t got, want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[OBW-1:0];
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected transaction", got, 0);
			end else begin
				want = answers_due.pop_front();
				if (got.distance != want.distance)
					report_mismatch("signed_distance", got.distance, want.distance);
				if (got.side != want.side)
					report_mismatch("side", got.side, want.side);
				if (got.coll != want.coll)
					report_mismatch("colliding", got.coll, want.coll);
				if (got.degen != want.degen)
					report_mismatch("plane_degenerate", got.degen, want.degen);
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		answer_t on_plane;
		pt_a = '0;
		pt_b = '0;
		pt_c = '0;
		plane_valid = 1'b0;
		nrm = '{0, 0, 0};
		offs = 0;
		degen_flag = 1'b0;
		on_plane = '{degen: 1'b1, coll: 1'b1, side: SIDE_ON, distance: '0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		r = '{default: '0};
		r.q = mk_q(32767, -32768, 32767, 0); r.typed = 1; r.ans = on_plane; rows.push_back(r);
		r.q = mk_q(-32768, 32767, -32768, 65535); rows.push_back(r);
		r = '{default: '0};
		r.is_cfg = 1; r.idx = REG_A; r.val = pack_pt(256, 0, 0); rows.push_back(r);
		r.idx = REG_C; r.val = pack_pt(0, 256, 0); rows.push_back(r);
		r = '{default: '0};
		r.q = mk_q(0, 0, 256, 0); r.typed = 1;
		r.ans = '{degen: 1'b0, coll: 1'b0, side: SIDE_POS, distance: 18'sd256};
		rows.push_back(r);
		r.q = mk_q(0, 0, -256, 256);
		r.ans = '{degen: 1'b0, coll: 1'b1, side: SIDE_NEG, distance: -18'sd256};
		rows.push_back(r);
		r.q = mk_q(100, -77, 0, 0);
		r.ans = '{degen: 1'b0, coll: 1'b1, side: SIDE_ON, distance: 18'sd0};
		rows.push_back(r);
		r = '{default: '0};
		r.q = mk_q(32767, 32767, 32767, 65535); rows.push_back(r);
		r.q = mk_q(-32768, -32768, -32768, 0); rows.push_back(r);
		r.q = mk_q(0, 0, -1, 0); rows.push_back(r);
		r = '{default: '0};
		r.is_cfg = 1; r.idx = REG_A; r.val = pack_pt(-32768, 32767, -32768); rows.push_back(r);
		r.idx = REG_B; r.val = pack_pt(32767, -32768, 32767); rows.push_back(r);
		r.idx = REG_C; r.val = pack_pt(-32768, -32768, 32767); rows.push_back(r);
		r = '{default: '0};
		r.q = mk_q(32767, 32767, -32768, 0); rows.push_back(r);
		r.q = mk_q(-32768, -32768, 32767, 65535); rows.push_back(r);
		r.q = mk_q(0, 0, 0, 1); rows.push_back(r);
		r = '{default: '0};
		r.is_cfg = 1; r.idx = REG_B; r.val = pack_pt(-32768, 32767, -32768); rows.push_back(r);
		r = '{default: '0};
		r.q = mk_q(1234, -999, 4321, 7); r.typed = 1; r.ans = on_plane; rows.push_back(r);
		r.q = mk_q(-1, -1, -1, 65535); rows.push_back(r);

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_reg(rows[i].idx, rows[i].val);
			else
				send_query(rows[i].q, rows[i].typed, rows[i].ans);
		end

		for (int ph = 0; ph < 20; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			if (ph % 3 == 0)
				write_reg(REG_A, rand_pt(ph % 2 == 0));
			if (ph % 3 == 1)
				write_reg(REG_B, rand_pt(ph % 2 == 0));
			if (ph % 3 == 2)
				write_reg(REG_C, rand_pt(ph % 2 == 0));
			if (ph == 5) begin
				fork
					begin
						hold_recv = 1'b1;
						repeat (300) @(posedge clk);
						hold_recv = 1'b0;
					end
				join_none
			end
			for (int k = 0; k < 100; k++) begin
				send_query(rand_q($urandom_range(3) != 0), 0, on_plane);
			end
			if (ph == 10)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
